[design/tlqe_pkg.sv]
`timescale 1ns / 1ps
package tlqe_pkg;

  localparam int COORD_W  = 24;
  localparam int HW_W     = 20;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int LEN2_W   = 2 * DIFF_W;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int PROD_W   = DIFF_W + HW_W;
  localparam int NUM_W    = PROD_W + 7;
  localparam int QUO_W    = HW_W + 1;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = QUO_W + 1;
  localparam int MAG_W    = 32;
  localparam int OFS_W    = MAG_W + 1;
  localparam int SUM_W    = OFS_W + 1;

  localparam logic [HW_W-1:0] HALF_WIDTH_RESET = HW_W'(1049);

  typedef logic signed [COORD_W-1:0] coord_t;

  // endpoints and offset control carried beside the arithmetic
  typedef struct packed {
    coord_t bx;
    coord_t by;
    coord_t ex;
    coord_t ey;
    logic   neg_x;
    logic   neg_y;
    logic   degen;
  } side_t;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2 ** (COORD_W - 1) - 1);
    lo = -SUM_W'(2 ** (COORD_W - 1));
    if (v > hi) return coord_t'(hi);
    else if (v < lo) return coord_t'(lo);
    else return coord_t'(v);
  endfunction

endpackage

[design/tlqe_sqrt.sv]
`timescale 1ns / 1ps
module tlqe_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tlqe_pkg::RAD_W-1:0]  rad,
  output logic [tlqe_pkg::ROOT_W-1:0] root
);
  import tlqe_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_q  [SQRT_LAT];
  logic [ROOT_W-1:0] root_q [SQRT_LAT];
  logic [RAD_W-1:0]  rad_q  [SQRT_LAT];

  // one result bit per stage, restoring
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    always_comb begin
      shifted = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial   = {1'b0, root_in, 2'b01};
      ge      = (shifted >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? (shifted - trial) : shifted;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQRT_LAT-1];

endmodule

[design/tlqe_div.sv]
`timescale 1ns / 1ps
module tlqe_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tlqe_pkg::NUM_W-1:0]  num,
  input  logic [tlqe_pkg::ROOT_W-1:0] den,
  output logic [tlqe_pkg::QUO_W-1:0]  quo
);
  import tlqe_pkg::*;

  localparam int RND_W = NUM_W + 1;
  localparam int STEPS = QUO_W;

  logic [ROOT_W-1:0] rem_q [DIV_LAT];
  logic [ROOT_W-1:0] den_q [DIV_LAT];
  logic [QUO_W-1:0]  low_q [DIV_LAT];
  logic [RND_W-1:0]  rnd;

  // round half up, then split into starting remainder and dividend tail
  always_comb begin
    rnd = RND_W'(num) + RND_W'(den >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= rnd[RND_W-1 -: ROOT_W];
      low_q[0] <= rnd[QUO_W-1:0];
      den_q[0] <= den;
    end
  end

  // one quotient bit per stage; low_q collects quotient bits as dividend bits leave
  for (genvar k = 1; k <= STEPS; k++) begin : g_stage
    logic [ROOT_W:0] shifted;
    logic            ge;

    always_comb begin
      shifted = {rem_q[k-1], low_q[k-1][QUO_W-1]};
      ge      = (shifted >= {1'b0, den_q[k-1]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? ROOT_W'(shifted - {1'b0, den_q[k-1]}) : ROOT_W'(shifted);
        low_q[k] <= {low_q[k-1][QUO_W-2:0], ge};
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign quo = low_q[DIV_LAT-1];

endmodule

[design/thick_line_quad_expand_top.sv]
`timescale 1ns / 1ps
// Expands a line segment into the four corners of a thick-line quad. One segment is
// taken every cycle unless the output stalls; the depth comes from the 32-stage
// square root of the squared length followed by two 22-stage dividers, one per
// axis, each retiring one bit per stage after a rounding stage. A stalled output
// freezes the whole pipeline. Each entering segment samples hw_reg, set on cfg_valid.
module thick_line_quad_expand_top #(
  parameter int COORD_FRAC_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tlqe_pkg::HW_W-1:0]   line_half_width,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tlqe_pkg::coord_t            begin_x,
  input  tlqe_pkg::coord_t            begin_y,
  input  tlqe_pkg::coord_t            end_x,
  input  tlqe_pkg::coord_t            end_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tlqe_pkg::coord_t            begin_top_x,
  output tlqe_pkg::coord_t            begin_top_y,
  output tlqe_pkg::coord_t            begin_bottom_x,
  output tlqe_pkg::coord_t            begin_bottom_y,
  output tlqe_pkg::coord_t            end_bottom_x,
  output tlqe_pkg::coord_t            end_bottom_y,
  output tlqe_pkg::coord_t            end_top_x,
  output tlqe_pkg::coord_t            end_top_y,
  output logic                        degenerate
);
  import tlqe_pkg::*;

  localparam int MID_LAT = SQRT_LAT + DIV_LAT;
  localparam int TOTAL   = 4 + MID_LAT + 2;
  localparam int LAST    = TOTAL - 1;

  logic [HW_W-1:0] hw_reg;
  logic [TOTAL-1:0] vld;
  logic en;

  // stage registers
  coord_t s1_bx, s1_by, s1_ex, s1_ey;
  logic [HW_W-1:0] s1_w, s2_w;
  logic signed [DIFF_W-1:0] dx_c, dy_c;
  logic [DIFF_W-1:0] adx_c, ady_c;
  coord_t s2_bx, s2_by, s2_ex, s2_ey;
  logic [DIFF_W-1:0] s2_adx, s2_ady;
  logic s2_negx, s2_negy;
  coord_t s3_bx, s3_by, s3_ex, s3_ey;
  logic s3_negx, s3_negy;
  logic [LEN2_W-1:0] s3_sqx, s3_sqy;
  logic [PROD_W-1:0] s3_px, s3_py;
  logic [LEN2_W-1:0] len2_c;
  side_t s4_side;
  logic [LEN2_W-1:0] s4_len2;
  logic [NUM_W-1:0] s4_nx, s4_ny;
  side_t side_q [MID_LAT];
  logic [NUM_W-1:0] numx_q [SQRT_LAT];
  logic [NUM_W-1:0] numy_q [SQRT_LAT];
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0] qx, qy;
  logic [MAG_W-1:0] mx_c, my_c;
  logic signed [OFS_W-1:0] sc_nx, sc_ny;
  side_t sc_side;

  // whole pipeline advances unless the held result is refused
  assign en        = !vld[LAST] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[LAST];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hw_reg <= HALF_WIDTH_RESET;
    end else if (cfg_valid) begin
      hw_reg <= line_half_width;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], in_valid};
    end
  end

  // stage 1: capture transaction
  always_ff @(posedge clk) begin
    if (en) begin
      s1_bx <= begin_x;
      s1_by <= begin_y;
      s1_ex <= end_x;
      s1_ey <= end_y;
      s1_w  <= hw_reg;
    end
  end

  // stage 2: difference and magnitude
  always_comb begin
    dx_c  = DIFF_W'(s1_ex) - DIFF_W'(s1_bx);
    dy_c  = DIFF_W'(s1_ey) - DIFF_W'(s1_by);
    adx_c = dx_c[DIFF_W-1] ? DIFF_W'(-dx_c) : DIFF_W'(dx_c);
    ady_c = dy_c[DIFF_W-1] ? DIFF_W'(-dy_c) : DIFF_W'(dy_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bx   <= s1_bx;
      s2_by   <= s1_by;
      s2_ex   <= s1_ex;
      s2_ey   <= s1_ey;
      s2_w    <= s1_w;
      s2_adx  <= adx_c;
      s2_ady  <= ady_c;
      s2_negx <= !dy_c[DIFF_W-1] && (dy_c != '0);
      s2_negy <= dx_c[DIFF_W-1];
    end
  end

  // stage 3: squares and scaled rotated components
  always_ff @(posedge clk) begin
    if (en) begin
      s3_bx   <= s2_bx;
      s3_by   <= s2_by;
      s3_ex   <= s2_ex;
      s3_ey   <= s2_ey;
      s3_negx <= s2_negx;
      s3_negy <= s2_negy;
      s3_sqx  <= LEN2_W'(s2_adx * s2_adx);
      s3_sqy  <= LEN2_W'(s2_ady * s2_ady);
      s3_px   <= PROD_W'(s2_ady * s2_w);
      s3_py   <= PROD_W'(s2_adx * s2_w);
    end
  end

  // stage 4: squared length and dividends
  assign len2_c = s3_sqx + s3_sqy;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_len2       <= len2_c;
      s4_nx         <= {s3_px, 7'b0};
      s4_ny         <= {s3_py, 7'b0};
      s4_side.bx    <= s3_bx;
      s4_side.by    <= s3_by;
      s4_side.ex    <= s3_ex;
      s4_side.ey    <= s3_ey;
      s4_side.neg_x <= s3_negx;
      s4_side.neg_y <= s3_negy;
      s4_side.degen <= (len2_c == '0);
    end
  end

  // length with seven extra fraction bits
  tlqe_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({s4_len2, 14'b0}),
    .root (root)
  );

  // delay lines beside the root and divide
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= s4_side;
      numx_q[0] <= s4_nx;
      numy_q[0] <= s4_ny;
      for (int i = 1; i < MID_LAT; i++) side_q[i] <= side_q[i-1];
      for (int i = 1; i < SQRT_LAT; i++) begin
        numx_q[i] <= numx_q[i-1];
        numy_q[i] <= numy_q[i-1];
      end
    end
  end

  tlqe_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (numx_q[SQRT_LAT-1]),
    .den (root),
    .quo (qx)
  );

  tlqe_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (numy_q[SQRT_LAT-1]),
    .den (root),
    .quo (qy)
  );

  // offset magnitude to coordinate units
  if (COORD_FRAC_BITS >= HW_W) begin : g_up
    assign mx_c = MAG_W'(qx) << (COORD_FRAC_BITS - HW_W);
    assign my_c = MAG_W'(qy) << (COORD_FRAC_BITS - HW_W);
  end else begin : g_down
    localparam int SH = HW_W - COORD_FRAC_BITS;
    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (SH - 1);
    assign mx_c = (MAG_W'(qx) + HALF) >> SH;
    assign my_c = (MAG_W'(qy) + HALF) >> SH;
  end

  // scale stage: apply sign, zero offset for a degenerate segment
  always_ff @(posedge clk) begin
    if (en) begin
      sc_side <= side_q[MID_LAT-1];
      if (side_q[MID_LAT-1].degen) begin
        sc_nx <= '0;
        sc_ny <= '0;
      end else begin
        sc_nx <= side_q[MID_LAT-1].neg_x ? -$signed({1'b0, mx_c}) : $signed({1'b0, mx_c});
        sc_ny <= side_q[MID_LAT-1].neg_y ? -$signed({1'b0, my_c}) : $signed({1'b0, my_c});
      end
    end
  end

  // output stage: corners with saturation
  always_ff @(posedge clk) begin
    if (en) begin
      begin_top_x    <= sat_coord(SUM_W'(sc_side.bx) + SUM_W'(sc_nx));
      begin_top_y    <= sat_coord(SUM_W'(sc_side.by) + SUM_W'(sc_ny));
      begin_bottom_x <= sat_coord(SUM_W'(sc_side.bx) - SUM_W'(sc_nx));
      begin_bottom_y <= sat_coord(SUM_W'(sc_side.by) - SUM_W'(sc_ny));
      end_bottom_x   <= sat_coord(SUM_W'(sc_side.ex) - SUM_W'(sc_nx));
      end_bottom_y   <= sat_coord(SUM_W'(sc_side.ey) - SUM_W'(sc_ny));
      end_top_x      <= sat_coord(SUM_W'(sc_side.ex) + SUM_W'(sc_nx));
      end_top_y      <= sat_coord(SUM_W'(sc_side.ey) + SUM_W'(sc_ny));
      degenerate     <= sc_side.degen;
    end
  end

  // a degenerate segment leaves top and bottom corners equal
  a_degen_flat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |->
      (begin_top_x == begin_bottom_x) && (begin_top_y == begin_bottom_y) &&
      (end_top_x == end_bottom_x) && (end_top_y == end_bottom_y))
    else $error("degenerate result with nonzero offset");

  // input is refused only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // no result leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
